FILE: src/spq_pkg.sv
// Package with the types, constants and codes of the stable sorted priority queue.
package spq_pkg;

    localparam int DEPTH          = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int PAYLOAD_WIDTH  = 16;
    localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);

    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic                      kind;
        logic [PRIORITY_WIDTH-1:0] priority_req;
        logic [PAYLOAD_WIDTH-1:0]  payload;
    } in_word_t;

    typedef struct packed {
        logic [PAYLOAD_WIDTH-1:0] out_payload;
        logic [1:0]               status;
        logic [COUNT_WIDTH-1:0]   occupancy;
    } out_word_t;

    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic [PRIORITY_WIDTH-1:0] priority_req;
        logic [PAYLOAD_WIDTH-1:0]  payload;
    } cell_cmd_t;

    typedef struct packed {
        logic                      valid;
        logic                      behind;
        logic [PRIORITY_WIDTH-1:0] priority_val;
        logic [PAYLOAD_WIDTH-1:0]  payload;
    } cell_link_t;

endpackage

FILE: src/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it to or from its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_cmd_t  cmd,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    output cell_link_t own_link
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [PRIORITY_WIDTH-1:0] priority_reg;
    logic [PRIORITY_WIDTH-1:0] priority_next;
    logic [PAYLOAD_WIDTH-1:0]  payload_reg;
    logic [PAYLOAD_WIDTH-1:0]  payload_next;
    logic                      behind;

    // An empty slot or one with a larger priority value lies behind a new entry.
    assign behind = !valid_reg || (priority_reg > cmd.priority_req);

    assign own_link.valid        = valid_reg;
    assign own_link.behind       = behind;
    assign own_link.priority_val = priority_reg;
    assign own_link.payload      = payload_reg;

    always_comb begin
        valid_next    = valid_reg;
        priority_next = priority_reg;
        payload_next  = payload_reg;
        if (cmd.insert) begin
            if (prev_link.behind) begin
                valid_next    = prev_link.valid;
                priority_next = prev_link.priority_val;
                payload_next  = prev_link.payload;
            end else if (behind) begin
                valid_next    = 1'b1;
                priority_next = cmd.priority_req;
                payload_next  = cmd.payload;
            end
        end else if (cmd.remove) begin
            valid_next    = next_link.valid;
            priority_next = next_link.priority_val;
            payload_next  = next_link.payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        priority_reg <= priority_next;
        payload_reg  <= payload_next;
    end

endmodule

FILE: src/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: command decode, cell chain and result register.
//
// The queue holds up to DEPTH entries in a chain of cells kept in ascending order of
// priority value; equal values stay in arrival order. For every word all cells compare the
// new priority in parallel and shift by one place in the same edge, so an enqueue or a
// dequeue is accepted in every cycle in which the result register is free or being emptied.
// Each word gives one result word, registered, in the cycle after it is accepted.
// An enqueue into a full queue reports full and stores nothing; a dequeue from an empty
// queue reports empty and returns a zero payload.
module stable_sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    logic                   m_valid_reg;
    logic                   m_valid_next;
    out_word_t              m_word_reg;
    out_word_t              m_word_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   accept;
    logic                   full;
    logic                   empty;
    cell_cmd_t              cmd;
    cell_link_t             links [DEPTH];
    cell_link_t             head_link;
    cell_link_t             tail_link;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_WIDTH'(DEPTH));
    assign empty   = (count_reg == '0);

    assign cmd.insert       = accept && (s_word.kind == KIND_ENQUEUE) && !full;
    assign cmd.remove       = accept && (s_word.kind == KIND_DEQUEUE) && !empty;
    assign cmd.priority_req = s_word.priority_req;
    assign cmd.payload      = s_word.payload;

    assign head_link = '{valid: 1'b1, behind: 1'b0, priority_val: '0, payload: '0};
    assign tail_link = '{valid: 1'b0, behind: 1'b1, priority_val: '0, payload: '0};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                if (DEPTH == 1) begin : g_only
                    spq_cell u_cell (
                        .aclk      (aclk),
                        .aresetn   (aresetn),
                        .cmd       (cmd),
                        .prev_link (head_link),
                        .next_link (tail_link),
                        .own_link  (links[g])
                    );
                end else begin : g_many
                    spq_cell u_cell (
                        .aclk      (aclk),
                        .aresetn   (aresetn),
                        .cmd       (cmd),
                        .prev_link (head_link),
                        .next_link (links[g+1]),
                        .own_link  (links[g])
                    );
                end
            end else if (g == DEPTH - 1) begin : g_last
                spq_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .cmd       (cmd),
                    .prev_link (links[g-1]),
                    .next_link (tail_link),
                    .own_link  (links[g])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .cmd       (cmd),
                    .prev_link (links[g-1]),
                    .next_link (links[g+1]),
                    .own_link  (links[g])
                );
            end
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_word_next  = m_word_reg;
        if (accept) begin
            m_valid_next            = 1'b1;
            m_word_next.out_payload = '0;
            if (s_word.kind == KIND_ENQUEUE) begin
                if (full) begin
                    m_word_next.status = STATUS_FULL;
                end else begin
                    m_word_next.status = STATUS_INSERTED;
                    count_next         = count_reg + COUNT_WIDTH'(1);
                end
            end else begin
                if (empty) begin
                    m_word_next.status = STATUS_EMPTY;
                end else begin
                    m_word_next.status      = STATUS_REMOVED;
                    m_word_next.out_payload = links[0].payload;
                    count_next              = count_reg - COUNT_WIDTH'(1);
                end
            end
            m_word_next.occupancy = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

FILE: test/stable_sorted_priority_queue_test.sv
// Self-checking testbench for the stable sorted priority queue, with a built-in queue predictor.
module stable_sorted_priority_queue_test
    import spq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [PAYLOAD_WIDTH-1:0]  pay;
    } entry_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_word;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    entry_t    stored_entries[$];
    out_word_t pending_results[$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        no_gaps = 1'b0;

    stable_sorted_priority_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_word_t queue_response(input in_word_t w);
        out_word_t r;
        entry_t    e;
        int        pos;
        r = '0;
        if (w.kind == KIND_ENQUEUE) begin
            if (stored_entries.size() >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                e.prio = w.priority_req;
                e.pay  = w.payload;
                pos = stored_entries.size();
                for (int i = 0; i < stored_entries.size(); i++) begin
                    if (stored_entries[i].prio > w.priority_req) begin
                        pos = i;
                        break;
                    end
                end
                stored_entries.insert(pos, e);
                r.status = STATUS_INSERTED;
            end
        end else if (stored_entries.size() == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            e = stored_entries.pop_front();
            r.out_payload = e.pay;
            r.status      = STATUS_REMOVED;
        end
        r.occupancy = COUNT_WIDTH'(stored_entries.size());
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is accepted.
    task automatic send_word(input in_word_t w);
        if (!no_gaps && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(queue_response(w));
        @(negedge aclk);
    endtask

    function automatic in_word_t make_word(input logic kind, input int prio, input int pay);
        in_word_t w;
        w.kind         = kind;
        w.priority_req = PRIORITY_WIDTH'(prio);
        w.payload      = PAYLOAD_WIDTH'(pay);
        return w;
    endfunction

    function automatic in_word_t random_word(input int enqueue_pct, input bit tie_heavy);
        logic kind;
        int   prio;
        kind = ($urandom_range(99) < enqueue_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
        case ($urandom_range(9))
            0:       prio = 0;
            1:       prio = (1 << PRIORITY_WIDTH) - 1;
            2, 3, 4: prio = tie_heavy ? $urandom_range(3) : $urandom_range(255);
            default: prio = tie_heavy ? $urandom_range(7) : $urandom();
        endcase
        return make_word(kind, prio, $urandom());
    endfunction

    task automatic test_directed_cases();
        int prios[16] = '{255, 0, 128, 128, 128, 0, 1, 254, 255, 7, 128, 0, 64, 3, 200, 1};
        send_word(make_word(KIND_DEQUEUE, 255, 16'hffff));
        for (int i = 0; i < DEPTH; i++) begin
            send_word(make_word(KIND_ENQUEUE, prios[i], (i == 0) ? 16'hffff : i));
        end
        send_word(make_word(KIND_ENQUEUE, 0, 16'h5a5a));
        repeat (4) send_word(make_word(KIND_DEQUEUE, $urandom(), $urandom()));
    endtask

    task automatic test_random_traffic();
        for (int round = 0; round < 8; round++) begin
            repeat (40) send_word(random_word(80, round[0]));
            repeat (30) send_word(random_word(50, round[0]));
            repeat (40) send_word(random_word(20, round[0]));
        end
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        repeat (150) send_word(random_word(55, 1'b1));
        no_gaps = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= aresetn && (no_gaps || $urandom_range(99) >= 9);
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result word: payload %h status %0d occupancy %0d",
                             m_word.out_payload, m_word.status, m_word.occupancy);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_word.out_payload !== want.out_payload || m_word.status !== want.status
                        || m_word.occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected %h %0d %0d, got %h %0d %0d",
                                 want.out_payload, want.status, want.occupancy,
                                 m_word.out_payload, m_word.status, m_word.occupancy);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_traffic();
        test_back_to_back();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
